// File: hw/rtl/packed_sorted_key_search_macros.svh
// Assertion macros for the packed sorted key search block.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef PACKED_SORTED_KEY_SEARCH_MACROS_SVH
`define PACKED_SORTED_KEY_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PSKS_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSKS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hw/rtl/psks_pkg.sv
// Shared types and constants for the packed sorted key search block.
// No dependencies; every RTL file of the block imports this package.
package psks_pkg;

    // Input commands; code 3 is ignored
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXACT = 2'd1,
        CMD_FLOOR = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_ENTRY_WIDTH = 1'b0;
    localparam logic [0:0] CFG_ENTRY_COUNT = 1'b1;

    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned POS_W      = 10;
    localparam logic [5:0]  WIDTH_MAX  = 6'd32;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [9:0]       word_addr;
        logic [KEY_W-1:0] word_data;
        logic [KEY_W-1:0] search_key;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } out_item_t;

    // Controller state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DIV,
        ST_MOD,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic wr;
        logic step_mid;
        logic step_div;
        logic step_mod;
        logic step_read;
        logic step_cmp;
        logic load_out;
    } psks_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic more;
        logic hit;
    } psks_stat_t;

endpackage

// File: hw/rtl/psks_ctrl.sv
// Controller state machine for the packed sorted key search block.
// Depends on psks_pkg; drives the datapath through psks_cmd_t.
module psks_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             in_cmd,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  psks_pkg::psks_stat_t   stat,
    output psks_pkg::psks_cmd_t    cmd
);
    import psks_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one probe: midpoint, quotient, word address, read, compare
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else if (in_cmd == CMD_EXACT || in_cmd == CMD_FLOOR)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (stat.more)
                begin
                    cmd.step_mid = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.step_div = 1'b1;
                state_next   = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.step_mod = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                cmd.step_read = 1'b1;
                state_next    = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.step_cmp = 1'b1;
                state_next   = stat.hit ? ST_FINISH : ST_PROBE;
            end
            ST_FINISH:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/psks_dp.sv
// Datapath for the packed sorted key search: packed word store, config
// registers, search bounds, key extraction and result register. Uses psks_pkg.
module psks_dp #(
    parameter int unsigned STORE_WORDS = 1024,
    parameter int unsigned MAX_KEYS    = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [psks_pkg::CFG_DATA_W-1:0] cfg_data,
    input  psks_pkg::in_item_t              in_data,
    input  psks_pkg::psks_cmd_t             cmd,
    output psks_pkg::psks_stat_t            stat,
    output psks_pkg::out_item_t             out_data
);
    import psks_pkg::*;

    localparam int unsigned IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned AW = $clog2(STORE_WORDS);
    localparam int unsigned RW = ((IW > AW) ? IW : AW) + 1;
    // floor(2^32 / STORE_WORDS): word index times this, upper half, is the
    // quotient or one below it
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / STORE_WORDS);

    // Ones in the low w bits, w from 0 to 32
    function automatic logic [KEY_W-1:0] key_mask(input logic [5:0] w);
        logic [KEY_W:0] m;
        m = ({{KEY_W{1'b0}}, 1'b1} << w) - {{KEY_W{1'b0}}, 1'b1};
        return m[KEY_W-1:0];
    endfunction

    logic [5:0]            width_reg;
    logic [CFG_DATA_W-1:0] count_reg;

    logic [CW-1:0]    lo_reg, hp_reg;
    logic [IW-1:0]    mid_reg, word_reg, q_reg, hitpos_reg;
    logic [4:0]       off_reg;
    logic [AW-1:0]    a0_reg;
    logic [KEY_W-1:0] rd0_reg, rd1_reg, target_reg, mask_reg;
    logic [5:0]       weff_reg;
    logic             floor_reg, hit_reg;
    out_item_t        out_reg;

    logic [KEY_W-1:0] mem [STORE_WORDS];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 6'd1;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRY_WIDTH: width_reg <= cfg_data[5:0];
                CFG_ENTRY_COUNT: count_reg <= cfg_data;
                default:         width_reg <= width_reg;
            endcase
        end
    end

    // Saturate width and count
    logic [5:0]    weff_c;
    logic [16:0]   cnt17, n17;
    logic [CW-1:0] n_c;
    always_comb
    begin
        weff_c = (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
        cnt17  = 17'(count_reg);
        n17    = (cnt17 > 17'(MAX_KEYS)) ? 17'(MAX_KEYS) : cnt17;
        n_c    = n17[CW-1:0];
    end

    // Midpoint and its stream bit address
    logic [CW:0]   sum_c, lo_inc_c;
    logic [CW-1:0] mid_full_c;
    logic [IW-1:0] mid_c;
    logic [IW+5:0] bit_c;
    always_comb
    begin
        sum_c      = {1'b0, lo_reg} + {1'b0, hp_reg};
        mid_full_c = sum_c[CW:1];
        mid_c      = mid_full_c[IW-1:0];
        bit_c      = (IW+6)'(mid_c) * (IW+6)'(weff_reg);
        lo_inc_c   = {1'b0, lo_reg} + (CW+1)'(1);
    end

    // Loop conditions: hp holds one past the upper bound
    logic more_c;
    always_comb
    begin
        if (floor_reg)
        begin
            more_c = (lo_inc_c < {1'b0, hp_reg});
        end
        else
        begin
            more_c = (lo_reg < hp_reg);
        end
    end

    // Word index modulo the store size
    logic [IW+31:0] qprod_c;
    logic [IW+16:0] qd_c;
    logic [IW-1:0]  r0_c;
    logic [RW-1:0]  r0e_c, r_c;
    logic [AW-1:0]  a1_c;
    always_comb
    begin
        qprod_c = (IW+32)'(word_reg) * (IW+32)'(RECIP);
        qd_c    = (IW+17)'(q_reg) * (IW+17)'(STORE_WORDS);
        r0_c    = word_reg - qd_c[IW-1:0];
        r0e_c   = RW'(r0_c);
        r_c     = (r0e_c >= RW'(STORE_WORDS)) ? (r0e_c - RW'(STORE_WORDS)) : r0e_c;
        a1_c    = (a0_reg == AW'(STORE_WORDS - 1)) ? '0 : (a0_reg + AW'(1));
    end

    // Extract the key from the word pair and compare
    logic [2*KEY_W-1:0] pair_c, shifted_c;
    logic [KEY_W-1:0]   key_c;
    logic               eq_c, gt_c, hit_c;
    always_comb
    begin
        pair_c    = {rd1_reg, rd0_reg};
        shifted_c = pair_c >> off_reg;
        key_c     = shifted_c[KEY_W-1:0] & mask_reg;
        eq_c      = (key_c == target_reg);
        gt_c      = (key_c > target_reg);
        hit_c     = !floor_reg && eq_c;
    end

    // Status to the controller
    assign stat = '{more: more_c, hit: hit_c};

    // Store write port and the two registered read ports
    logic [16:0]   wa17;
    logic [AW-1:0] wa_c;
    logic          wr_ok_c;
    always_comb
    begin
        wa17    = 17'(in_data.word_addr);
        wa_c    = wa17[AW-1:0];
        wr_ok_c = (wa17 < 17'(STORE_WORDS));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_ok_c)
        begin
            mem[wa_c] <= in_data.word_data;
        end
        if (cmd.step_read)
        begin
            rd0_reg <= mem[a0_reg];
            rd1_reg <= mem[a1_c];
        end
    end

    // Search payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            target_reg <= in_data.search_key;
            weff_reg   <= weff_c;
            mask_reg   <= key_mask(weff_c);
        end
        if (cmd.step_mid)
        begin
            mid_reg  <= mid_c;
            word_reg <= bit_c[IW+4:5];
            off_reg  <= bit_c[4:0];
        end
        if (cmd.step_div)
        begin
            q_reg <= qprod_c[IW+31:32];
        end
        if (cmd.step_mod)
        begin
            a0_reg <= r_c[AW-1:0];
        end
        if (cmd.step_cmp && hit_c)
        begin
            hitpos_reg <= mid_reg;
        end
    end

    // Search bounds and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= '0;
            hp_reg    <= '0;
            floor_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else if (cmd.start)
        begin
            lo_reg    <= '0;
            floor_reg <= (in_data.cmd == CMD_FLOOR);
            hit_reg   <= 1'b0;
            if (in_data.cmd == CMD_FLOOR && n_c == '0)
            begin
                hp_reg <= CW'(1);
            end
            else
            begin
                hp_reg <= n_c;
            end
        end
        else if (cmd.step_cmp)
        begin
            if (floor_reg)
            begin
                if (gt_c)
                begin
                    hp_reg <= CW'(mid_reg);
                end
                else
                begin
                    lo_reg <= CW'(mid_reg);
                end
            end
            else if (eq_c)
            begin
                hit_reg <= 1'b1;
            end
            else if (gt_c)
            begin
                hp_reg <= CW'(mid_reg);
            end
            else
            begin
                lo_reg <= CW'(mid_reg) + CW'(1);
            end
        end
    end

    // Result register
    logic [16:0] pos17_c;
    always_comb
    begin
        if (floor_reg)
        begin
            pos17_c = 17'(lo_reg);
        end
        else if (hit_reg)
        begin
            pos17_c = 17'(hitpos_reg);
        end
        else
        begin
            pos17_c = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.found    <= floor_reg || hit_reg;
            out_reg.position <= pos17_c[POS_W-1:0];
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/packed_sorted_key_search.sv
// Packed sorted key search, top level. A write is taken in the idle state. A search
// runs probes (midpoint, quotient, word address, store read, compare) until the
// bounds close or an exact probe hits, then loads the result in a finish state.
// One item is in work at a time; a finished result
// waits in the output register while the next item is accepted.
// Reset (rst_n, async) sets entry_width 1, entry_count 0; the store is not cleared.
`include "packed_sorted_key_search_macros.svh"

module packed_sorted_key_search #(
    parameter int unsigned STORE_WORDS = 1024,
    parameter int unsigned MAX_KEYS    = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [psks_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  psks_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output psks_pkg::out_item_t             out_data
);
    import psks_pkg::*;

    psks_cmd_t  cmd;
    psks_stat_t stat;

    // Sequencer
    psks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store, bounds and key extraction
    psks_dp #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_KEYS    (MAX_KEYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // Input transfer and its kind, for the checks below
    logic in_xfer, search_xfer, write_xfer;
    assign in_xfer     = in_valid && !in_stall;
    assign search_xfer = in_xfer && (in_data.cmd == CMD_EXACT || in_data.cmd == CMD_FLOOR);
    assign write_xfer  = in_xfer && (in_data.cmd == CMD_WRITE);

    // A search transfer blocks further input on the next cycle
    `PSKS_ASSERT_NEXT(a_search_busy, search_xfer, in_stall, "search accepted, input not stalled")

    // A store write never produces a result
    `PSKS_ASSERT_NEXT(a_write_silent, write_xfer && !out_valid, !out_valid, "write made a result")

    // A miss reports position zero
    `PSKS_ASSERT_IMPLY(a_miss_pos_zero, out_valid && !out_data.found, out_data.position == 10'd0, "miss, nonzero position")

endmodule
